// ===== design/tts_pkg.sv =====
// Package for the text token scanner: result and control types, character codes
// and the character class functions used by the scanner core.
// No dependencies.
`timescale 1ns / 1ps

package tts_pkg;

    localparam int DATA_W     = 48;
    localparam int POS_W      = 9;
    localparam int IDENT_KEEP = 12;
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = 2;
    localparam int RES_CNT_W  = 3;

    localparam logic [7:0] C_NUL   = 8'o000;
    localparam logic [7:0] C_LF    = 8'o012;
    localparam logic [7:0] C_SPACE = 8'o040;
    localparam logic [7:0] C_STAR  = 8'o052;
    localparam logic [7:0] C_MINUS = 8'o055;
    localparam logic [7:0] C_SLASH = 8'o057;
    localparam logic [7:0] C_ZERO  = 8'o060;
    localparam logic [7:0] C_NINE  = 8'o071;
    localparam logic [7:0] C_UP_LO = 8'o101;
    localparam logic [7:0] C_UP_HI = 8'o132;
    localparam logic [7:0] C_LW_LO = 8'o140;
    localparam logic [7:0] C_LW_HI = 8'o176;

    localparam logic [POS_W-1:0] POS_MAX = 9'd511;
    localparam logic [39:0] SPACE_PAD = 40'h2020202020;

    localparam logic [2:0] KIND_ERROR  = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_IDENT  = 3'd4;
    localparam logic [2:0] KIND_EMPTY  = 3'd6;
    localparam logic [2:0] CH_EOL      = 3'd0;
    localparam logic [2:0] CH_DIGIT    = 3'd1;
    localparam logic [2:0] CH_LETTER   = 3'd2;
    localparam logic [2:0] CH_DELIM    = 3'd3;

    localparam logic CFG_STAR_SLASH = 1'b0;
    localparam logic CFG_CHAR_MODE  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_NUM   = 2'd1,
        PH_MINUS = 2'd2,
        PH_IDENT = 2'd3
    } t_phase;

    typedef struct packed {
        logic star_slash_letters;
        logic char_scan_mode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       new_string;
    } t_item;

    typedef struct packed {
        logic [2:0]        token_kind;
        logic [DATA_W-1:0] main_word;
        logic [DATA_W-1:0] aux_word;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic logic is_dec_digit(input logic [7:0] c);
        return c inside {[C_ZERO:C_NINE]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c, input logic star_slash);
        return (c inside {[C_UP_LO:C_UP_HI], [C_LW_LO:C_LW_HI]}) ||
               (star_slash && (c inside {C_STAR, C_SLASH}));
    endfunction

endpackage

// ===== design/tts_if.sv =====
// Request and result channel interfaces of the text token scanner.
// Depends on tts_pkg for the field widths.
`timescale 1ns / 1ps

interface tts_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       new_string;

    modport source (output valid, output char_byte, output new_string, input ready);
    modport sink (input valid, input char_byte, input new_string, output ready);
endinterface

interface tts_res_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                token_kind;
    logic [tts_pkg::DATA_W-1:0] main_word;
    logic [tts_pkg::DATA_W-1:0] aux_word;
    logic                      last_result;

    modport source (output valid, output token_kind, output main_word, output aux_word,
                    output last_result, input ready);
    modport sink (input valid, input token_kind, input main_word, input aux_word,
                  input last_result, output ready);
endinterface

// ===== design/tts_in_stage.sv =====
// Input register of the scanner: holds one request until the core consumes it.
// Depends on tts_pkg and tts_req_if.
`timescale 1ns / 1ps

module tts_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tts_req_if.sink        i_req,
    input  logic           i_proc,
    output logic           o_valid,
    output tts_pkg::t_item o_item
);
    import tts_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign i_req.ready = !r_valid || i_proc;
    assign w_load      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_proc) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.char_byte  <= i_req.char_byte;
            r_item.new_string <= i_req.new_string;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/tts_scan_core.sv =====
// Scanner core: token state, octal accumulator and identifier buffer, updated once
// per consumed request and producing up to two results. Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_scan_core #(
    parameter int MAX_IDENT_LEN = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_proc,
    input  tts_pkg::t_item i_item,
    input  tts_pkg::t_cfg  i_cfg,
    output tts_pkg::t_push o_push
);
    import tts_pkg::*;

    localparam int LEN_W = $clog2(MAX_IDENT_LEN + 1);

    t_phase                r_phase, n_phase;
    logic                  r_started, n_started;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_W-1:0]     r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic [7:0]            r_chars [IDENT_KEEP];
    logic [7:0]            n_chars [IDENT_KEEP];
    logic [LEN_W-1:0]      r_len, n_len;
    logic [DATA_W-1:0]     r_aux, n_aux;
    t_push                 w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_started <= 1'b0;
            r_pos     <= '0;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_len     <= '0;
            r_aux     <= '0;
            for (int i = 0; i < IDENT_KEEP; i++) begin
                r_chars[i] <= C_SPACE;
            end
        end else begin
            r_phase   <= n_phase;
            r_started <= n_started;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_neg     <= n_neg;
            r_len     <= n_len;
            r_aux     <= n_aux;
            r_chars   <= n_chars;
        end
    end

    always_comb begin
        logic [7:0]        c;
        logic [3:0]        d;
        logic              fall;
        logic              idle_v;
        t_result           idle_r;
        logic              give;
        logic [2:0]        ch_kind;

        c       = i_item.char_byte;
        d       = 4'(c - C_ZERO);
        fall    = 1'b0;
        idle_v  = 1'b0;
        idle_r  = '0;
        give    = 1'b0;
        ch_kind = CH_DELIM;

        n_phase   = r_phase;
        n_started = r_started;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_len     = r_len;
        n_aux     = r_aux;
        n_chars   = r_chars;
        w_push    = '0;

        if (i_proc) begin
            if (i_item.new_string) begin
                n_started = 1'b1;
                n_pos     = '0;
                n_phase   = PH_IDLE;
                n_acc     = '0;
                n_neg     = 1'b0;
                n_len     = '0;
            end

            if (!i_item.new_string && !r_started) begin
                w_push.v0 = 1'b1;
                w_push.r0 = '{KIND_ERROR, '0, r_aux, 1'b0};
            end else begin
                if (n_pos < POS_MAX) begin
                    n_pos = n_pos + 1'b1;
                end

                if (i_cfg.char_scan_mode) begin
                    n_phase = PH_IDLE;
                    if (c == C_NUL || c == C_LF) begin
                        ch_kind = CH_EOL;
                    end else if (is_dec_digit(c)) begin
                        ch_kind = CH_DIGIT;
                    end else if (is_letter(c, i_cfg.star_slash_letters)) begin
                        ch_kind = CH_LETTER;
                    end
                    n_aux     = {15'd0, n_pos, 16'd0, c};
                    w_push.v0 = 1'b1;
                    w_push.r0 = '{ch_kind, {c, SPACE_PAD}, n_aux, 1'b0};
                end else begin
                    case (n_phase)
                        PH_MINUS: begin
                            if (is_dec_digit(c)) begin
                                n_neg   = 1'b1;
                                n_acc   = {44'd0, d};
                                n_phase = PH_NUM;
                            end else begin
                                w_push.v0 = 1'b1;
                                w_push.r0 = '{KIND_EMPTY, {40'd0, C_MINUS}, r_aux, 1'b0};
                                n_phase   = PH_IDLE;
                                fall      = 1'b1;
                            end
                        end
                        PH_NUM: begin
                            if (is_dec_digit(c)) begin
                                n_acc = {r_acc[DATA_W-4:0], 3'b000} + {44'd0, d};
                            end else begin
                                n_aux     = {15'd0, n_pos, 16'd0, c};
                                n_phase   = PH_IDLE;
                                w_push.v0 = 1'b1;
                                w_push.r0 = '{KIND_NUMBER, (r_neg ? (~r_acc + 1'b1) : r_acc),
                                              n_aux, 1'b0};
                            end
                        end
                        PH_IDENT: begin
                            if (is_letter(c, i_cfg.star_slash_letters) || is_dec_digit(c)) begin
                                for (int i = 0; i < IDENT_KEEP; i++) begin
                                    if (r_len == LEN_W'(i)) begin
                                        n_chars[i] = c;
                                    end
                                end
                                n_len = r_len + 1'b1;
                                give  = (n_len >= LEN_W'(MAX_IDENT_LEN));
                            end else begin
                                give = 1'b1;
                            end
                            if (give) begin
                                n_aux     = {n_chars[6], n_chars[7], n_chars[8],
                                             n_chars[9], n_chars[10], n_chars[11]};
                                n_phase   = PH_IDLE;
                                w_push.v0 = 1'b1;
                                w_push.r0 = '{KIND_IDENT,
                                              {n_chars[0], n_chars[1], n_chars[2],
                                               n_chars[3], n_chars[4], n_chars[5]},
                                              n_aux, 1'b0};
                            end
                        end
                        default: begin
                            fall = 1'b1;
                        end
                    endcase

                    if (fall) begin
                        if (c == C_NUL || c == C_LF) begin
                            idle_v = 1'b1;
                            idle_r = '{KIND_EMPTY, {40'd0, c}, r_aux, 1'b0};
                        end else if (c == C_SPACE) begin
                            idle_v = 1'b0;
                        end else if (is_dec_digit(c)) begin
                            n_acc   = {44'd0, d};
                            n_neg   = 1'b0;
                            n_phase = PH_NUM;
                        end else if (c == C_MINUS) begin
                            n_phase = PH_MINUS;
                        end else if (is_letter(c, i_cfg.star_slash_letters)) begin
                            for (int i = 0; i < IDENT_KEEP; i++) begin
                                n_chars[i] = C_SPACE;
                            end
                            n_chars[0] = c;
                            n_len      = LEN_W'(1);
                            n_phase    = PH_IDENT;
                        end else begin
                            idle_v = 1'b1;
                            idle_r = '{KIND_EMPTY, {40'd0, c}, r_aux, 1'b0};
                        end

                        if (w_push.v0) begin
                            w_push.v1 = idle_v;
                            w_push.r1 = idle_r;
                        end else begin
                            w_push.v0 = idle_v;
                            w_push.r0 = idle_r;
                        end
                    end
                end
            end

            if (w_push.v1) begin
                w_push.r1.last_result = 1'b1;
            end else if (w_push.v0) begin
                w_push.r0.last_result = 1'b1;
            end
        end
    end

    assign o_push = w_push;

endmodule

// ===== design/tts_result_fifo.sv =====
// Result queue of the scanner: takes up to two results a cycle and presents one
// on the result channel. Depends on tts_pkg and tts_res_if.
`timescale 1ns / 1ps

module tts_result_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tts_pkg::t_push                i_push,
    tts_res_if.source                     o_res,
    output logic [tts_pkg::RES_CNT_W-1:0] o_count
);
    import tts_pkg::*;

    t_result               r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [RES_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [RES_CNT_W-1:0]  r_count, n_count;
    logic                  w_pop;
    logic [RES_PTR_W-1:0]  w_wr_next;
    t_result               w_head;

    assign w_pop     = o_res.valid && o_res.ready;
    assign w_wr_next = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + RES_PTR_W'(i_push.v0) + RES_PTR_W'(i_push.v1);
        n_rd_ptr = r_rd_ptr + RES_PTR_W'(w_pop);
        n_count  = r_count + RES_CNT_W'(i_push.v0) + RES_CNT_W'(i_push.v1)
                   - RES_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[w_wr_next] <= i_push.r1;
        end
    end

    assign w_head            = r_mem[r_rd_ptr];
    assign o_res.valid       = (r_count != '0);
    assign o_res.token_kind  = w_head.token_kind;
    assign o_res.main_word   = w_head.main_word;
    assign o_res.aux_word    = w_head.aux_word;
    assign o_res.last_result = w_head.last_result;
    assign o_count           = r_count;

endmodule

// ===== design/text_token_scanner.sv =====
// Top level of the text token scanner: configuration registers, input register,
// scanner core and result queue. Depends on tts_pkg, tts_if and the tts_ modules.
//
// Channel  | Direction | Payload
// i_req    | in        | char_byte, new_string
// o_res    | out       | token_kind, main_word, aux_word, last_result
// i_cfg_*  | in        | write enable, register index, data
//
// One request is taken per cycle while the input register is empty or consumed;
// its results enter the result queue as the core consumes it. A byte ending a
// lone minus gives up to two results. Reset clears all scanner state. The core
// consumes a request only while the queue holds at most two results, so a
// stalled result channel stops the request channel after a short fill.
`timescale 1ns / 1ps

module text_token_scanner #(
    parameter int MAX_IDENT_LEN = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [0:0] i_cfg_data,
    tts_req_if.sink    i_req,
    tts_res_if.source  o_res
);
    import tts_pkg::*;

    t_cfg                  r_cfg;
    logic                  w_in_valid;
    t_item                 w_item;
    logic                  w_proc;
    t_push                 w_push;
    logic [RES_CNT_W-1:0]  w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_STAR_SLASH: r_cfg.star_slash_letters <= i_cfg_data[0];
                CFG_CHAR_MODE:  r_cfg.char_scan_mode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_proc = w_in_valid && (w_count <= RES_CNT_W'(RES_DEPTH - 2));

    tts_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_proc  (w_proc),
        .o_valid (w_in_valid),
        .o_item  (w_item)
    );

    tts_scan_core #(
        .MAX_IDENT_LEN (MAX_IDENT_LEN)
    ) u_scan_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (w_proc),
        .i_item  (w_item),
        .i_cfg   (r_cfg),
        .o_push  (w_push)
    );

    tts_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_res   (o_res),
        .o_count (w_count)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.v1 |-> (w_push.v0 && w_proc))
        else $error("second result without a first");

    a_held_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_proc) |=> w_in_valid)
        else $error("request dropped before being consumed");
`endif

endmodule
